// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion shorthands used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/issp_pkg.sv -----
// ---------------------------------------------------------------------------
// issp_pkg
// types and character constants of the sequence-set parser
// ---------------------------------------------------------------------------
package issp_pkg;

  localparam int VALUE_BITS_DEF = 63;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BAD    = 2'd1,
    STATUS_MARKER = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    COLON_NONE = 2'd0,
    COLON_ONE  = 2'd1,
    COLON_TWO  = 2'd2
  } colon_t;

  typedef struct packed {
    logic    end_open;
    status_t status;
    logic    set_done;
  } flags_t;

endpackage

// ----- hw/rtl/issp_if.sv -----
// ---------------------------------------------------------------------------
// issp_in_if / issp_out_if
// valid/ready channels for text bytes and parsed intervals
// ---------------------------------------------------------------------------
interface issp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface issp_out_if #(
  parameter int VALUE_BITS = issp_pkg::VALUE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_BITS-1:0]  range_start;
  logic [VALUE_BITS-1:0]  range_end;
  logic                   end_open;
  issp_pkg::status_t      status;
  logic                   set_done;

  modport source (output valid, output range_start, output range_end,
                  output end_open, output status, output set_done, input ready);
  modport sink   (input valid, input range_start, input range_end,
                  input end_open, input status, input set_done, output ready);
endinterface

// ----- hw/rtl/issp_seg_core.sv -----
// ---------------------------------------------------------------------------
// issp_seg_core
// per-segment parse state, one byte per cycle, result on segment close
// ---------------------------------------------------------------------------
module issp_seg_core #(
  parameter int VALUE_BITS = issp_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            byte_in,
  input  logic                  last_byte,
  output logic                  res_valid,
  output logic [VALUE_BITS-1:0] res_start,
  output logic [VALUE_BITS-1:0] res_end,
  output issp_pkg::flags_t      res_flags
);

  localparam int PROD_BITS = VALUE_BITS + 4;

  logic                  nonempty_r, nonempty_nxt;
  issp_pkg::colon_t      colon_r, colon_nxt;
  logic [VALUE_BITS-1:0] first_r, first_nxt;
  logic [VALUE_BITS-1:0] second_r, second_nxt;
  logic                  first_dig_r, first_dig_nxt;
  logic                  second_dig_r, second_dig_nxt;
  logic                  star_r, star_nxt;
  logic                  bad_r, bad_nxt;

  // state after the byte itself, before any close
  logic                  nonempty_t;
  issp_pkg::colon_t      colon_t;
  logic [VALUE_BITS-1:0] first_t;
  logic [VALUE_BITS-1:0] second_t;
  logic                  first_dig_t;
  logic                  second_dig_t;
  logic                  star_t;
  logic                  bad_t;

  logic                  is_comma;
  logic                  is_digit;
  logic                  close_seg;
  logic                  seg_bad;
  logic [VALUE_BITS-1:0] acc_sel;
  logic [PROD_BITS-1:0]  prod;
  logic                  ovf;

  assign is_comma = (byte_in == issp_pkg::CH_COMMA);
  assign is_digit = (byte_in >= issp_pkg::CH_ZERO) && (byte_in <= issp_pkg::CH_NINE);

  // acc * 10 + digit, one shared multiply-add for both values
  assign acc_sel = (colon_r == issp_pkg::COLON_NONE) ? first_r : second_r;
  assign prod    = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0}
                 + {{(PROD_BITS-4){1'b0}}, byte_in[3:0]};
  assign ovf     = |prod[PROD_BITS-1:VALUE_BITS];

  always_comb begin
    nonempty_t   = nonempty_r;
    colon_t      = colon_r;
    first_t      = first_r;
    second_t     = second_r;
    first_dig_t  = first_dig_r;
    second_dig_t = second_dig_r;
    star_t       = star_r;
    bad_t        = bad_r;
    if (!is_comma) begin
      nonempty_t = 1'b1;
      if (!bad_r) begin
        if (byte_in == issp_pkg::CH_COLON) begin
          if (colon_r != issp_pkg::COLON_NONE) begin
            colon_t = issp_pkg::COLON_TWO;
            bad_t   = 1'b1;
          end else begin
            colon_t = issp_pkg::COLON_ONE;
          end
        end else if (byte_in == issp_pkg::CH_STAR) begin
          if (colon_r != issp_pkg::COLON_ONE || second_dig_r || star_r) begin
            bad_t = 1'b1;
          end else begin
            star_t = 1'b1;
          end
        end else if (is_digit) begin
          if (colon_r == issp_pkg::COLON_NONE) begin
            if (ovf) begin
              bad_t = 1'b1;
            end else begin
              first_t     = prod[VALUE_BITS-1:0];
              first_dig_t = 1'b1;
            end
          end else if (star_r || ovf) begin
            bad_t = 1'b1;
          end else begin
            second_t     = prod[VALUE_BITS-1:0];
            second_dig_t = 1'b1;
          end
        end else begin
          bad_t = 1'b1;
        end
      end
    end
  end

  assign close_seg = is_comma || last_byte;
  assign seg_bad   = bad_t || !first_dig_t
                   || (colon_t == issp_pkg::COLON_ONE && !second_dig_t && !star_t);

  always_comb begin
    res_valid          = close_seg && (nonempty_t || last_byte);
    res_start          = '0;
    res_end            = '0;
    res_flags.end_open = 1'b0;
    res_flags.status   = issp_pkg::STATUS_OK;
    res_flags.set_done = last_byte;
    if (!nonempty_t) begin
      res_flags.status = issp_pkg::STATUS_MARKER;
    end else if (seg_bad) begin
      res_flags.status = issp_pkg::STATUS_BAD;
    end else if (colon_t == issp_pkg::COLON_NONE) begin
      res_start = first_t;
      res_end   = first_t;
    end else if (star_t) begin
      res_start          = first_t;
      res_flags.end_open = 1'b1;
    end else begin
      res_start = first_t;
      res_end   = second_t;
    end
  end

  always_comb begin
    nonempty_nxt   = nonempty_r;
    colon_nxt      = colon_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    first_dig_nxt  = first_dig_r;
    second_dig_nxt = second_dig_r;
    star_nxt       = star_r;
    bad_nxt        = bad_r;
    if (take) begin
      if (close_seg) begin
        nonempty_nxt   = 1'b0;
        colon_nxt      = issp_pkg::COLON_NONE;
        first_nxt      = '0;
        second_nxt     = '0;
        first_dig_nxt  = 1'b0;
        second_dig_nxt = 1'b0;
        star_nxt       = 1'b0;
        bad_nxt        = 1'b0;
      end else begin
        nonempty_nxt   = nonempty_t;
        colon_nxt      = colon_t;
        first_nxt      = first_t;
        second_nxt     = second_t;
        first_dig_nxt  = first_dig_t;
        second_dig_nxt = second_dig_t;
        star_nxt       = star_t;
        bad_nxt        = bad_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r   <= 1'b0;
      colon_r      <= issp_pkg::COLON_NONE;
      first_r      <= '0;
      second_r     <= '0;
      first_dig_r  <= 1'b0;
      second_dig_r <= 1'b0;
      star_r       <= 1'b0;
      bad_r        <= 1'b0;
    end else begin
      nonempty_r   <= nonempty_nxt;
      colon_r      <= colon_nxt;
      first_r      <= first_nxt;
      second_r     <= second_nxt;
      first_dig_r  <= first_dig_nxt;
      second_dig_r <= second_dig_nxt;
      star_r       <= star_nxt;
      bad_r        <= bad_nxt;
    end
  end

endmodule

// ----- hw/rtl/issp_out_buf.sv -----
// ---------------------------------------------------------------------------
// issp_out_buf
// result register with a skid entry, registered ready toward the input
// ---------------------------------------------------------------------------
module issp_out_buf #(
  parameter int DATA_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              can_take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic              main_valid_r, main_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic [DATA_W-1:0] main_data_r, main_data_nxt;
  logic [DATA_W-1:0] skid_data_r, skid_data_nxt;
  logic              pop;

  assign pop       = main_valid_r && out_ready;
  assign can_take  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_data_nxt  = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

// ----- hw/rtl/imap_sequence_set_parser.sv -----
// A closing byte (comma or last byte) that is accepted has its result registered.
// One byte per cycle while ready is high; segment state updates in one pass per byte.
// A result register plus one skid entry keep input flowing while a result waits.
// Ready drops only when both the result register and the skid entry are occupied.
// Synchronous active-low reset clears segment state and both output entries.
// ---------------------------------------------------------------------------
// imap_sequence_set_parser
// streams sequence-set text and emits one interval per closed non-empty segment
// ---------------------------------------------------------------------------
module imap_sequence_set_parser #(
  parameter int VALUE_BITS = issp_pkg::VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  issp_in_if.sink   in_ch,
  issp_out_if.source out_ch
);

  localparam int FLAG_W = $bits(issp_pkg::flags_t);
  localparam int DATA_W = 2 * VALUE_BITS + FLAG_W;

  logic                  take;
  logic                  can_take;
  logic                  res_valid;
  logic [VALUE_BITS-1:0] res_start;
  logic [VALUE_BITS-1:0] res_end;
  issp_pkg::flags_t      res_flags;
  issp_pkg::flags_t      out_flags;
  logic [DATA_W-1:0]     out_data;

  assign in_ch.ready = can_take;
  assign take        = in_ch.valid && can_take;

  issp_seg_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_seg_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .byte_in   (in_ch.byte_in),
    .last_byte (in_ch.last_byte),
    .res_valid (res_valid),
    .res_start (res_start),
    .res_end   (res_end),
    .res_flags (res_flags)
  );

  issp_out_buf #(
    .DATA_W (DATA_W)
  ) u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take && res_valid),
    .push_data ({res_start, res_end, res_flags}),
    .can_take  (can_take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.range_start = out_data[DATA_W-1 -: VALUE_BITS];
  assign out_ch.range_end   = out_data[FLAG_W +: VALUE_BITS];
  assign out_flags          = out_data[FLAG_W-1:0];
  assign out_ch.end_open    = out_flags.end_open;
  assign out_ch.status      = out_flags.status;
  assign out_ch.set_done    = out_flags.set_done;

endmodule

// ----- hw/rtl/issp_checker.sv -----
// ---------------------------------------------------------------------------
// issp_checker
// port-level checks on the parser results, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module issp_checker #(
  parameter int VALUE_BITS = issp_pkg::VALUE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [VALUE_BITS-1:0] range_start,
  input logic [VALUE_BITS-1:0] range_end,
  input logic                  end_open,
  input logic [1:0]            status,
  input logic                  set_done
);

  logic is_marker;
  logic is_bad;
  logic zero_range;

  assign is_marker  = out_valid && (status == issp_pkg::STATUS_MARKER);
  assign is_bad     = out_valid && (status == issp_pkg::STATUS_BAD);
  assign zero_range = (range_start == '0) && (range_end == '0);

  // result stays valid while stalled
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // input only stalls with a pending result
  `ASSERT_IMPLIES(a_stall_has_result, clk, rst_n, !in_ready, out_valid)
  // marker carries no interval and ends the set
  `ASSERT_IMPLIES(a_marker_shape, clk, rst_n, is_marker, set_done && !end_open && zero_range)
  // malformed segment is reported as 0:0
  `ASSERT_IMPLIES(a_bad_shape, clk, rst_n, is_bad, !end_open && zero_range)
  // open end only on a valid interval with end zero
  `ASSERT_IMPLIES(a_open_shape, clk, rst_n, out_valid && end_open, status == issp_pkg::STATUS_OK && range_end == '0)

endmodule

bind imap_sequence_set_parser issp_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_issp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .range_start (out_ch.range_start),
  .range_end   (out_ch.range_end),
  .end_open    (out_ch.end_open),
  .status      (out_ch.status),
  .set_done    (out_ch.set_done)
);

// ----- tb/tb_imap_sequence_set_parser.sv -----
// ---------------------------------------------------------------------------
// tb_imap_sequence_set_parser
// drives sequence-set text byte by byte, predicts every interval, marker and
// malformed result from a behavioral copy of the segment state, and checks
// each accepted result field by field under random idling on both channels
// ---------------------------------------------------------------------------
module tb_imap_sequence_set_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB = issp_pkg::VALUE_BITS_DEF;
  localparam longint unsigned VALUE_MAX = (64'd1 << VB) - 64'd1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic [VB-1:0]     range_start;
    logic [VB-1:0]     range_end;
    logic              end_open;
    issp_pkg::status_t status;
    logic              set_done;
  } interval_t;

  class interval_board;
    bit                seg_nonempty;
    issp_pkg::colon_t  colons;
    longint unsigned   first_val;
    longint unsigned   second_val;
    bit                first_digits;
    bit                second_digits;
    bit                second_star;
    bit                seg_bad;
    interval_t         expected_q[$];
    int unsigned       mismatches;

    function void clear_segment();
      seg_nonempty  = 0;
      colons        = issp_pkg::COLON_NONE;
      first_val     = 0;
      second_val    = 0;
      first_digits  = 0;
      second_digits = 0;
      second_star   = 0;
      seg_bad       = 0;
    endfunction

    function new();
      clear_segment();
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit push_digit(inout longint unsigned acc, input longint unsigned d);
      if (acc > (VALUE_MAX - d) / 10) return 0;
      acc = acc * 10 + d;
      return 1;
    endfunction

    function void take_char(logic [7:0] c);
      longint unsigned d;
      seg_nonempty = 1;
      if (seg_bad) return;
      if (c == issp_pkg::CH_COLON) begin
        if (colons != issp_pkg::COLON_NONE) begin
          colons  = issp_pkg::COLON_TWO;
          seg_bad = 1;
        end else begin
          colons = issp_pkg::COLON_ONE;
        end
      end else if (c == issp_pkg::CH_STAR) begin
        if (colons != issp_pkg::COLON_ONE || second_digits || second_star) seg_bad = 1;
        else second_star = 1;
      end else if (c >= issp_pkg::CH_ZERO && c <= issp_pkg::CH_NINE) begin
        d = c - issp_pkg::CH_ZERO;
        if (colons == issp_pkg::COLON_NONE) begin
          if (push_digit(first_val, d)) first_digits = 1;
          else seg_bad = 1;
        end else if (second_star) begin
          seg_bad = 1;
        end else begin
          if (push_digit(second_val, d)) second_digits = 1;
          else seg_bad = 1;
        end
      end else begin
        seg_bad = 1;
      end
    endfunction

    function void note_byte(logic [7:0] c, logic is_last);
      interval_t r;
      bit        bad;
      if (c != issp_pkg::CH_COMMA) take_char(c);
      if (c == issp_pkg::CH_COMMA || is_last) begin
        r.range_start = '0;
        r.range_end   = '0;
        r.end_open    = 1'b0;
        r.status      = issp_pkg::STATUS_OK;
        r.set_done    = is_last;
        if (seg_nonempty) begin
          bad = seg_bad || !first_digits ||
                (colons == issp_pkg::COLON_ONE && !second_digits && !second_star);
          if (bad) begin
            r.status = issp_pkg::STATUS_BAD;
          end else if (colons == issp_pkg::COLON_NONE) begin
            r.range_start = first_val[VB-1:0];
            r.range_end   = first_val[VB-1:0];
          end else if (second_star) begin
            r.range_start = first_val[VB-1:0];
            r.end_open    = 1'b1;
          end else begin
            r.range_start = first_val[VB-1:0];
            r.range_end   = second_val[VB-1:0];
          end
          expected_q.push_back(r);
        end else if (is_last) begin
          r.status = issp_pkg::STATUS_MARKER;
          expected_q.push_back(r);
        end
        clear_segment();
      end
    endfunction

    function void check_interval(interval_t got);
      interval_t exp;
      if (expected_q.size() == 0) begin
        $error("unexpected interval %0d:%0d status %0d", got.range_start, got.range_end,
               got.status);
        mismatches++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.range_start !== exp.range_start) begin
        $error("range_start: expected %0d, actual %0d", exp.range_start, got.range_start);
        mismatches++;
      end
      if (got.range_end !== exp.range_end) begin
        $error("range_end: expected %0d, actual %0d", exp.range_end, got.range_end);
        mismatches++;
      end
      if (got.end_open !== exp.end_open) begin
        $error("end_open: expected %0b, actual %0b", exp.end_open, got.end_open);
        mismatches++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        mismatches++;
      end
      if (got.set_done !== exp.set_done) begin
        $error("set_done: expected %0b, actual %0b", exp.set_done, got.set_done);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  issp_in_if                       in_ch ();
  issp_out_if #(.VALUE_BITS(VB))   out_ch ();

  imap_sequence_set_parser #(.VALUE_BITS(VB)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  interval_board board = new();
  logic [7:0]    set_text[$];
  bit            idle_on = 1;
  bit            hold_req = 0;
  int            hold_left = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   cycle_count;

  initial begin
    clk = 0;
  end

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // result side: check, then pick ready for the next edge
  initial begin
    interval_t got;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.range_start = out_ch.range_start;
        got.range_end   = out_ch.range_end;
        got.end_open    = out_ch.end_open;
        got.status      = out_ch.status;
        got.set_done    = out_ch.set_done;
        board.check_interval(got);
      end
      if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  task automatic send_byte(logic [7:0] c, logic is_last);
    if (idle_on && $urandom_range(0, 99) < 22) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.byte_in   <= c;
    in_ch.last_byte <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_byte(c, is_last);
    bytes_sent++;
  endtask

  task automatic send_request_text();
    for (int i = 0; i < set_text.size(); i++) send_byte(set_text[i], i == set_text.size() - 1);
  endtask

  task automatic send_string(string s);
    set_text.delete();
    for (int i = 0; i < s.len(); i++) set_text.push_back(s[i]);
    send_request_text();
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic void put_value(longint unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) set_text.push_back(s[i]);
  endfunction

  function automatic void put_number();
    longint unsigned v;
    case ($urandom_range(0, 19))
      12, 13: begin
        repeat ($urandom_range(1, 3)) set_text.push_back(issp_pkg::CH_ZERO);
        put_value($urandom_range(0, 999));
      end
      14: begin
        v = {$urandom(), $urandom()};
        put_value(v & VALUE_MAX);
      end
      15: put_value(VALUE_MAX - $urandom_range(0, 9));
      16: put_value(VALUE_MAX + $urandom_range(1, 9));
      17: repeat (20) set_text.push_back(8'(issp_pkg::CH_ZERO + $urandom_range(0, 9)));
      18: put_value(0);
      19: put_value($urandom());
      default: put_value($urandom_range(0, 999));
    endcase
  endfunction

  function automatic void put_segment();
    int first_idx;
    first_idx = set_text.size();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6: put_number();
      7, 8, 9, 10: begin
        put_number();
        set_text.push_back(issp_pkg::CH_COLON);
        put_number();
      end
      11, 12: begin
        put_number();
        set_text.push_back(issp_pkg::CH_COLON);
        set_text.push_back(issp_pkg::CH_STAR);
      end
      13: ;
      14: repeat ($urandom_range(1, 3)) set_text.push_back(8'($urandom_range(0, 255)));
      15: begin
        put_number();
        set_text.push_back(issp_pkg::CH_COLON);
        put_number();
        set_text.insert($urandom_range(first_idx, set_text.size()),
                        8'($urandom_range(0, 255)));
      end
      16: begin
        case ($urandom_range(0, 5))
          0: begin
            set_text.push_back(issp_pkg::CH_COLON);
            put_number();
          end
          1: begin
            put_number();
            set_text.push_back(issp_pkg::CH_COLON);
          end
          2: begin
            set_text.push_back(issp_pkg::CH_STAR);
            if ($urandom_range(0, 1)) begin
              set_text.push_back(issp_pkg::CH_COLON);
              put_number();
            end
          end
          3: begin
            put_number();
            set_text.push_back(issp_pkg::CH_COLON);
            set_text.push_back(issp_pkg::CH_STAR);
            put_number();
          end
          4: begin
            put_number();
            set_text.push_back(issp_pkg::CH_COLON);
            put_number();
            set_text.push_back(issp_pkg::CH_COLON);
            put_number();
          end
          default: begin
            put_number();
            set_text.push_back(issp_pkg::CH_COLON);
            set_text.push_back(issp_pkg::CH_STAR);
            set_text.push_back(issp_pkg::CH_STAR);
          end
        endcase
      end
      17: begin
        put_number();
        set_text.push_back(issp_pkg::CH_COLON);
        put_number();
        set_text.push_back(issp_pkg::CH_STAR);
      end
      18: begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0: set_text.push_back(issp_pkg::CH_COLON);
            1: set_text.push_back(issp_pkg::CH_STAR);
            default: set_text.push_back(8'(issp_pkg::CH_ZERO + $urandom_range(0, 9)));
          endcase
        end
      end
      default: begin
        case ($urandom_range(0, 2))
          0: set_text.push_back(" ");
          1: set_text.push_back("+");
          default: set_text.push_back("-");
        endcase
        put_number();
      end
    endcase
  endfunction

  task automatic send_random_set();
    int n_seg;
    set_text.delete();
    n_seg = $urandom_range(1, 5);
    for (int i = 0; i < n_seg; i++) begin
      if (i > 0) set_text.push_back(issp_pkg::CH_COMMA);
      put_segment();
    end
    if ($urandom_range(0, 99) < 15) set_text.push_back(issp_pkg::CH_COMMA);
    if (set_text.size() == 0) set_text.push_back(issp_pkg::CH_COMMA);
    send_request_text();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.byte_in   = '0;
    in_ch.last_byte = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // second colon, star first, star mixed, empty numbers, final comma
    send_string("1:2:3,*:5,7:*8,:5,6:,");
    // open end, sign, empty segments, final comma after an empty segment
    send_string("0:*,+,,");

    while (bytes_sent < 300) send_random_set();

    // fill the block while the result side holds off, then drain
    hold_req = 1;
    send_string("1,2,3,4:5,6:*,7,8,9,10,11,12,13");
    wait_drained();

    idle_on = 0;
    while (bytes_sent < 520) send_random_set();
    idle_on = 1;
    while (bytes_sent < 850) send_random_set();

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/issp_pkg.sv
hw/rtl/issp_if.sv
hw/rtl/issp_seg_core.sv
hw/rtl/issp_out_buf.sv
hw/rtl/imap_sequence_set_parser.sv
hw/rtl/issp_checker.sv
tb/tb_imap_sequence_set_parser.sv
